// ----- rtl/drema_pkg.sv -----
// Shared types, widths and constants for the divider resistance EMA filter.
`default_nettype none
package drema_pkg;

  localparam int ADC_BITS  = 10;
  localparam int FRAC_BITS = 16;

  localparam int SER_W   = 22;
  localparam int MAXR_W  = 31;
  localparam int ALPHA_W = FRAC_BITS + 1;
  localparam int AVG_W   = MAXR_W + FRAC_BITS;
  localparam int PROD_W  = SER_W + ADC_BITS;
  localparam int ACC_W   = AVG_W + FRAC_BITS + 1;
  localparam int CNT_W   = $clog2(PROD_W + 1);
  localparam int CFG_W   = MAXR_W;
  localparam int IDX_W   = 2;

  localparam logic [ADC_BITS-1:0] ADC_FS   = {ADC_BITS{1'b1}};
  localparam logic [ALPHA_W-1:0]  Q_ONE    = ALPHA_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0]    Q_HALF   = ACC_W'(1) << (FRAC_BITS - 1);

  localparam logic [SER_W-1:0]   SER_RST   = SER_W'(10000);
  localparam logic [MAXR_W-1:0]  MAXR_RST  = MAXR_W'(1000000);
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(6554);

  typedef enum logic [IDX_W-1:0] {
    REG_SERIES = 2'd0,
    REG_MAXR   = 2'd1,
    REG_ALPHA  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_PREP,
    ST_EMA,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/divider_resistance_ema_filter_core.sv -----
// Divider resistance with bit-serial multiply, divide and EMA update.
// Steps: single-bit shift-add multiply and restoring divide, clamp, EMA update, output register;
// a full-scale reading skips multiply and divide, the first sample skips the EMA.
// Requests are taken only in the idle state, not while one is in progress.
// A new request is taken while a result waits in the output register.
// Reset (rst_n low, synchronous) restores register defaults, clears the filter.
`default_nettype none
module divider_resistance_ema_filter_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [drema_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [drema_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [drema_pkg::ADC_BITS-1:0] in_adc_reading,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [drema_pkg::MAXR_W-1:0]        out_resistance_ohms,
  output logic [drema_pkg::AVG_W-1:0]         out_filtered_q16,
  output logic                                out_was_first
);

  localparam int ADC_BITS  = drema_pkg::ADC_BITS;
  localparam int FRAC_BITS = drema_pkg::FRAC_BITS;
  localparam int SER_W     = drema_pkg::SER_W;
  localparam int MAXR_W    = drema_pkg::MAXR_W;
  localparam int ALPHA_W   = drema_pkg::ALPHA_W;
  localparam int AVG_W     = drema_pkg::AVG_W;
  localparam int PROD_W    = drema_pkg::PROD_W;
  localparam int ACC_W     = drema_pkg::ACC_W;
  localparam int CNT_W     = drema_pkg::CNT_W;

  drema_pkg::state_t state_r, state_nxt;

  logic [SER_W-1:0]   series_r;
  logic [MAXR_W-1:0]  maxr_r;
  logic [ALPHA_W-1:0] alpha_r;

  logic               ready_r, ready_nxt;
  logic [AVG_W-1:0]   avg_r, avg_nxt;

  logic [ADC_BITS-1:0] rd_r, rd_nxt;
  logic [PROD_W-1:0]   mcand_r, mcand_nxt;
  logic [ADC_BITS-1:0] mplier_r, mplier_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [PROD_W-1:0]   quo_r, quo_nxt;
  logic [ADC_BITS-1:0] rem_r, rem_nxt;
  logic [ADC_BITS-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [MAXR_W-1:0]   res_r, res_nxt;
  logic [ALPHA_W-1:0]  wa_r, wa_nxt;
  logic [ALPHA_W-1:0]  wb_r, wb_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [MAXR_W-1:0]   out_res_r, out_res_nxt;
  logic [AVG_W-1:0]    out_filt_r, out_filt_nxt;
  logic                out_first_r, out_first_nxt;

  logic [ADC_BITS:0]   trial;
  logic [ADC_BITS:0]   trial_diff;
  logic [ALPHA_W-1:0]  alpha_sat;
  logic [AVG_W-1:0]    x_val;
  logic [ACC_W-1:0]    sum;
  logic                out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r <= drema_pkg::SER_RST;
      maxr_r   <= drema_pkg::MAXR_RST;
      alpha_r  <= drema_pkg::ALPHA_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        drema_pkg::REG_SERIES: series_r <= cfg_wdata[SER_W-1:0];
        drema_pkg::REG_MAXR:   maxr_r   <= cfg_wdata[MAXR_W-1:0];
        drema_pkg::REG_ALPHA:  alpha_r  <= cfg_wdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drema_pkg::ST_IDLE;
      ready_r     <= 1'b0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r        <= rd_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    prod_r      <= prod_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
    wa_r        <= wa_nxt;
    wb_r        <= wb_nxt;
    acc_r       <= acc_nxt;
    out_res_r   <= out_res_nxt;
    out_filt_r  <= out_filt_nxt;
    out_first_r <= out_first_nxt;
  end

  always_comb begin
    trial      = {rem_r, quo_r[PROD_W-1]};
    trial_diff = trial - {1'b0, den_r};
    alpha_sat  = (alpha_r > drema_pkg::Q_ONE) ? drema_pkg::Q_ONE : alpha_r;
    x_val      = {res_r, {FRAC_BITS{1'b0}}};
    sum        = acc_r + drema_pkg::Q_HALF;
    out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt     = state_r;
    ready_nxt     = ready_r;
    avg_nxt       = avg_r;
    rd_nxt        = rd_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    prod_nxt      = prod_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    out_filt_nxt  = out_filt_r;
    out_first_nxt = out_first_r;
    in_ready      = (state_r == drema_pkg::ST_IDLE);

    case (state_r)
      drema_pkg::ST_IDLE: begin
        if (in_valid) begin
          rd_nxt = in_adc_reading;
          if (in_adc_reading == drema_pkg::ADC_FS) begin
            res_nxt   = maxr_r;
            state_nxt = drema_pkg::ST_PREP;
          end else begin
            mcand_nxt  = PROD_W'(series_r);
            mplier_nxt = in_adc_reading;
            prod_nxt   = '0;
            cnt_nxt    = '0;
            state_nxt  = drema_pkg::ST_MUL;
          end
        end
      end
      drema_pkg::ST_MUL: begin
        if (mplier_r[0]) prod_nxt = prod_r + mcand_r;
        mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ADC_BITS - 1)) begin
          // divisor is FS - reading, never zero on this path
          den_nxt   = drema_pkg::ADC_FS - rd_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = drema_pkg::ST_DIV;
        end
      end
      drema_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          quo_nxt = prod_r;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          if (!trial_diff[ADC_BITS]) begin
            rem_nxt = trial_diff[ADC_BITS-1:0];
            quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
          end else begin
            rem_nxt = trial[ADC_BITS-1:0];
            quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
          end
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(PROD_W)) begin
            state_nxt = drema_pkg::ST_PREP;
          end
        end
      end
      drema_pkg::ST_PREP: begin
        // the divide result is still in quo_r unless the full-scale path set res_r
        if (rd_r != drema_pkg::ADC_FS) begin
          res_nxt = (quo_r > PROD_W'(maxr_r)) ? maxr_r : quo_r[MAXR_W-1:0];
          state_nxt = drema_pkg::ST_PREP;
          rd_nxt    = drema_pkg::ADC_FS;
        end else if (!ready_r) begin
          // first sample: acc = x << FRAC so the rounding step returns x
          acc_nxt   = ACC_W'(x_val) << FRAC_BITS;
          state_nxt = drema_pkg::ST_DONE;
        end else begin
          wa_nxt    = alpha_sat;
          wb_nxt    = drema_pkg::Q_ONE - alpha_sat;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = drema_pkg::ST_EMA;
        end
      end
      drema_pkg::ST_EMA: begin
        // MSB-first shift-add of x*a + avg*(1-a)
        acc_nxt = {acc_r[ACC_W-2:0], 1'b0}
                + (wa_r[ALPHA_W-1] ? ACC_W'(x_val) : '0)
                + (wb_r[ALPHA_W-1] ? ACC_W'(avg_r) : '0);
        wa_nxt  = {wa_r[ALPHA_W-2:0], 1'b0};
        wb_nxt  = {wb_r[ALPHA_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ALPHA_W - 1)) begin
          state_nxt = drema_pkg::ST_DONE;
        end
      end
      drema_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_filt_nxt  = sum[FRAC_BITS +: AVG_W];
          out_first_nxt = !ready_r;
          avg_nxt       = sum[FRAC_BITS +: AVG_W];
          ready_nxt     = 1'b1;
          state_nxt     = drema_pkg::ST_IDLE;
        end
      end
      default: state_nxt = drema_pkg::ST_IDLE;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_resistance_ohms = out_res_r;
  assign out_filtered_q16    = out_filt_r;
  assign out_was_first       = out_first_r;

endmodule
`default_nettype wire
